// ===== rtl/tfhd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfhd_pkg: shared types and constants of the tank sequencer
// Phase codes, register indexes, reset loads, request and result layouts.
// ----------------------------------------------------------------------------
package tfhd_pkg;

    localparam int TIMER_BITS_DEF = 10;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_LOADS      = 6;
    localparam int THR_W          = 10;
    localparam int TICKS_W        = 10;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 32;

    localparam logic [THR_W-1:0] THR_MIN   = 10'd10;
    localparam logic [THR_W-1:0] THR_MAX   = 10'd990;
    localparam logic [THR_W-1:0] THR_RESET = 10'd300;

    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_FILL_A     = 3'd1,
        PH_FILL_B     = 3'd2,
        PH_HEAT_FIXED = 3'd3,
        PH_HEAT_MAX   = 3'd4,
        PH_DRAIN      = 3'd5,
        PH_PAUSE      = 3'd6
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILL_A     = 3'd0,
        CFG_FILL_B     = 3'd1,
        CFG_HEAT_FIXED = 3'd2,
        CFG_HEAT_EXTRA = 3'd3,
        CFG_DRAIN      = 3'd4,
        CFG_PAUSE      = 3'd5
    } t_cfg_idx;

    typedef logic [NUM_LOADS-1:0][CFG_W-1:0] t_loads;

    localparam t_loads LOAD_RESET = {10'd20, 10'd20, 10'd100, 10'd100, 10'd10, 10'd30};

    typedef struct packed {
        logic lower_button;
        logic raise_button;
        logic temp_sensor;
        logic level_sensor;
        logic full_sensor;
    } t_tick;

    typedef struct packed {
        logic [THR_W-1:0]   threshold_tenths;
        logic [TICKS_W-1:0] ticks_left;
        logic [2:0]         phase;
        logic               heater_on;
        logic               drain_valve;
        logic               fill_valve_b;
        logic               fill_valve_a;
    } t_result;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

`default_nettype wire

// ===== rtl/tfhd_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfhd_cfg: phase load registers
// Six write-only counter loads, written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tfhd_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tfhd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tfhd_pkg::CFG_W-1:0]     i_cfg_wdata,
    output      tfhd_pkg::t_loads               o_loads
);
    import tfhd_pkg::*;

    t_loads r_loads;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loads <= LOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILL_A:     r_loads[CFG_FILL_A]     <= i_cfg_wdata;
                CFG_FILL_B:     r_loads[CFG_FILL_B]     <= i_cfg_wdata;
                CFG_HEAT_FIXED: r_loads[CFG_HEAT_FIXED] <= i_cfg_wdata;
                CFG_HEAT_EXTRA: r_loads[CFG_HEAT_EXTRA] <= i_cfg_wdata;
                CFG_DRAIN:      r_loads[CFG_DRAIN]      <= i_cfg_wdata;
                CFG_PAUSE:      r_loads[CFG_PAUSE]      <= i_cfg_wdata;
                default:        r_loads <= r_loads;
            endcase
        end
    end

    assign o_loads = r_loads;

endmodule

`default_nettype wire

// ===== rtl/tfhd_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfhd_step: phase sequencer, tick counter and threshold
// Computes one tick's result from the held state and advances on accept.
// ----------------------------------------------------------------------------
module tfhd_step #(
    parameter int TIMER_BITS = tfhd_pkg::TIMER_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire tfhd_pkg::t_tick   i_tick,
    input  wire tfhd_pkg::t_loads  i_loads,
    output      tfhd_pkg::t_result o_result
);
    import tfhd_pkg::*;

    logic [2:0]            r_phase;
    logic [TIMER_BITS-1:0] r_count;
    logic [THR_W-1:0]      r_thr;

    logic [2:0]            n_phase;
    logic [TIMER_BITS-1:0] n_count;
    logic [THR_W-1:0]      n_thr;

    logic                  w_enter;
    logic [CFG_W-1:0]      w_load;
    logic [TIMER_BITS-1:0] w_loaded;
    logic                  w_zero;
    logic [THR_W:0]        w_t;
    logic                  w_va;
    logic                  w_vb;
    logic                  w_vd;
    logic                  w_ht;

    assign w_zero = (r_count == '0);

    always_comb begin
        w_va    = 1'b0;
        w_vb    = 1'b0;
        w_vd    = 1'b0;
        w_ht    = 1'b0;
        w_enter = 1'b0;
        n_phase = r_phase;
        unique case (r_phase)
            PH_FILL_A: begin
                w_va = 1'b1;
                if (i_tick.full_sensor) begin
                    w_enter = 1'b1;
                    n_phase = PH_HEAT_FIXED;
                end else if (w_zero) begin
                    w_enter = 1'b1;
                    n_phase = PH_FILL_B;
                end
            end
            PH_FILL_B: begin
                w_vb = 1'b1;
                if (i_tick.full_sensor) begin
                    w_enter = 1'b1;
                    n_phase = PH_HEAT_FIXED;
                end else if (w_zero) begin
                    w_enter = 1'b1;
                    n_phase = PH_FILL_A;
                end
            end
            PH_HEAT_FIXED: begin
                w_ht = 1'b1;
                if (w_zero) begin
                    w_enter = 1'b1;
                    n_phase = i_tick.temp_sensor ? PH_DRAIN : PH_HEAT_MAX;
                end
            end
            PH_HEAT_MAX: begin
                w_ht = 1'b1;
                if (i_tick.temp_sensor || w_zero) begin
                    w_enter = 1'b1;
                    n_phase = PH_DRAIN;
                end
            end
            PH_DRAIN: begin
                w_vd = 1'b1;
                if (!i_tick.level_sensor) begin
                    w_enter = 1'b1;
                    n_phase = PH_FILL_A;
                end else if (w_zero) begin
                    w_enter = 1'b1;
                    n_phase = PH_PAUSE;
                end
            end
            PH_PAUSE: begin
                if (!i_tick.level_sensor) begin
                    w_enter = 1'b1;
                    n_phase = PH_FILL_A;
                end else if (w_zero) begin
                    w_enter = 1'b1;
                    n_phase = PH_DRAIN;
                end
            end
            // start phase and the unused code both move to fill A
            default: begin
                w_enter = 1'b1;
                n_phase = PH_FILL_A;
            end
        endcase
    end

    always_comb begin
        case (n_phase)
            PH_FILL_A:     w_load = i_loads[CFG_FILL_A];
            PH_FILL_B:     w_load = i_loads[CFG_FILL_B];
            PH_HEAT_FIXED: w_load = i_loads[CFG_HEAT_FIXED];
            PH_HEAT_MAX:   w_load = i_loads[CFG_HEAT_EXTRA];
            PH_DRAIN:      w_load = i_loads[CFG_DRAIN];
            PH_PAUSE:      w_load = i_loads[CFG_PAUSE];
            default:       w_load = '0;
        endcase
    end

    assign w_loaded = w_enter ? TIMER_BITS'(w_load) : r_count;

    // decrement on every step, also right after a load, stopping at zero
    assign n_count = (w_loaded != '0) ? w_loaded - 1'b1 : w_loaded;

    always_comb begin
        w_t = {1'b0, r_thr} + {{THR_W{1'b0}}, i_tick.raise_button};
        if (i_tick.lower_button && (w_t != '0)) begin
            w_t = w_t - 1'b1;
        end
        if (w_t > {1'b0, THR_MAX}) begin
            n_thr = THR_MAX;
        end else if (w_t < {1'b0, THR_MIN}) begin
            n_thr = THR_MIN;
        end else begin
            n_thr = w_t[THR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_count <= '0;
            r_thr   <= THR_RESET;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_thr   <= n_thr;
        end
    end

    always_comb begin
        o_result.fill_valve_a     = w_va;
        o_result.fill_valve_b     = w_vb;
        o_result.drain_valve      = w_vd;
        o_result.heater_on        = w_ht;
        o_result.phase            = n_phase;
        o_result.ticks_left       = TICKS_W'(n_count);
        o_result.threshold_tenths = n_thr;
    end

endmodule

`default_nettype wire

// ===== rtl/tfhd_oreg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfhd_oreg: result register with skid stage
// Holds up to two results so a request is taken while one still waits.
// ----------------------------------------------------------------------------
module tfhd_oreg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire tfhd_pkg::t_result     i_result,
    output      logic                  o_ready,
    output      logic                  o_valid,
    input  wire logic                  i_pop_ready,
    output      tfhd_pkg::t_result     o_result,
    output      tfhd_pkg::t_buf_status o_status
);
    import tfhd_pkg::*;

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop   = r_main_v && i_pop_ready;
    assign o_ready = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || w_pop) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || w_pop) begin
            r_main <= r_skid_v ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_valid             = r_main_v;
    assign o_result            = r_main;
    assign o_status.main_valid = r_main_v;
    assign o_status.skid_valid = r_skid_v;

endmodule

`default_nettype wire

// ===== rtl/tank_fill_heat_drain_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tank_fill_heat_drain_sequencer_core: tank fill, heat and drain sequencer
// One request per control tick; one result with drives, phase, counter and
// temperature threshold per request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: each request is one tick of sensor and button bits. The
//   request updates phase, tick counter and threshold at the accepting edge.
//   Master stream: one result per request, in order, from a result register,
//   or from the skid entry after a stall. Throughput is one request per cycle
//   while the buffer has room; the phase, counter and threshold update is a
//   single pass of logic between the state and result registers.
//   A two-entry result buffer keeps s_axis_tready high while one result waits;
//   if the receiver stalls with both entries full, s_axis_tready drops until a
//   result is taken.
//   Configuration: write phase loads through i_cfg_we/i_cfg_idx/i_cfg_wdata
//   while no request is in flight. Indexes beyond the last load are dropped.
//   Reset (synchronous, active low): start phase, counter zero, threshold
//   300 tenths, loads to their defaults, result buffer empty.
// ----------------------------------------------------------------------------
module tank_fill_heat_drain_sequencer_core #(
    parameter int TIMER_BITS = tfhd_pkg::TIMER_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // [0] full_sensor, [1] level_sensor, [2] temp_sensor, [3] raise_button,
    // [4] lower_button, [7:5] zero
    input  wire logic [tfhd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] fill_valve_a, [1] fill_valve_b, [2] drain_valve, [3] heater_on,
    // [6:4] phase, [16:7] ticks_left, [26:17] threshold_tenths, [31:27] zero
    output      logic [tfhd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [tfhd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tfhd_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import tfhd_pkg::*;

    t_loads      w_loads;
    t_tick       w_tick;
    t_result     w_result;
    t_result     w_out;
    t_buf_status w_status;
    logic        w_accept;

    assign w_tick   = t_tick'(s_axis_tdata[$bits(t_tick)-1:0]);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    tfhd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_loads     (w_loads)
    );

    tfhd_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_tick   (w_tick),
        .i_loads  (w_loads),
        .o_result (w_result)
    );

    tfhd_oreg u_oreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_result    (w_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_result    (w_out),
        .o_status    (w_status)
    );

    assign m_axis_tdata = M_TDATA_W'(w_out);

    a_phase_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out.phase != 3'd7))
        else $error("result carries unused phase code");

    a_thr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out.threshold_tenths >= THR_MIN
                           && w_out.threshold_tenths <= THR_MAX))
        else $error("threshold outside saturation range");

    a_skid_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.skid_valid |-> w_status.main_valid)
        else $error("skid entry held with empty result register");

    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && m_axis_tvalid && !m_axis_tready) |=> w_status.skid_valid)
        else $error("request dropped while result stalled");

endmodule

`default_nettype wire
